// File: src/nf4q_pkg.sv
// ----------------------------------------------------------------------------
// nf4q_pkg
// Shared types, sizes and the NF4 midpoint table for the NF4 block quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nf4q_pkg;

    localparam int MAX_BLOCK = 64;
    localparam int MAX_PAIRS = MAX_BLOCK / 2;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int FILL_W    = $clog2(MAX_BLOCK + 1);
    localparam int BYTE_W    = $clog2(MAX_PAIRS);
    localparam int PAIRS_W   = 6;
    localparam int SAMPLE_W  = 16;
    localparam int MID_W     = 17;
    localparam int THR_W     = 33;
    localparam int NUM_MIDS  = 15;
    localparam int STEP_W    = 2;

    localparam logic [PAIRS_W-1:0] PAIRS_RESET = PAIRS_W'(32);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_tensor;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          packed_byte;
        logic [SAMPLE_W-1:0] block_scale;
        logic                last_of_block;
        logic                last_of_tensor;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              thr_en;
        logic [3:0]        thr_sel;
        logic              rd_en;
        logic              srch_en;
        logic [STEP_W-1:0] step;
        logic [BYTE_W-1:0] byte_idx;
        logic              phase;
        logic              clear;
    } cmd_t;

    typedef struct packed {
        logic close_blk;
        logic lo_absent;
        logic last_byte;
    } stat_t;

    // Midpoints between adjacent NF4 levels, in units of 2^-16.
    function automatic logic signed [MID_W-1:0] nf4_mid(input logic [3:0] sel);
        logic signed [MID_W-1:0] m;
        case (sel)
            4'd0:    m = -17'sd55581;
            4'd1:    m = -17'sd40019;
            4'd2:    m = -17'sd30146;
            4'd3:    m = -17'sd22259;
            4'd4:    m = -17'sd15375;
            4'd5:    m = -17'sd9041;
            4'd6:    m = -17'sd2985;
            4'd7:    m = 17'sd2608;
            4'd8:    m = 17'sd7880;
            4'd9:    m = 17'sd13336;
            4'd10:   m = 17'sd19136;
            4'd11:   m = 17'sd25513;
            4'd12:   m = 17'sd32876;
            4'd13:   m = 17'sd42126;
            4'd14:   m = 17'sd56459;
            default: m = 17'sd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: src/nf4q_ram.sv
// ----------------------------------------------------------------------------
// nf4q_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nf4q_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/nf4q_datapath.sv
// ----------------------------------------------------------------------------
// nf4q_datapath
// Block store, running magnitude maximum, threshold registers, binary search
// over the thresholds and the output byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module nf4q_datapath
    import nf4q_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [PAIRS_W-1:0]  cfg_wdata,
    input  wire in_item_t            in_data,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    output out_item_t                out_data
);

    logic [PAIRS_W-1:0]     block_pairs_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [SAMPLE_W-1:0]    absmax_reg, absmax_next;
    logic signed [THR_W-1:0] thr_reg [0:NUM_MIDS-1];
    logic [3:0]             idx_reg, idx_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   tlast_reg;

    logic [FILL_W-1:0]      pairs_clamped;
    logic [FILL_W-1:0]      blk_len;
    logic [FILL_W-1:0]      fill_inc;
    logic [SAMPLE_W-1:0]    mag;
    logic [SAMPLE_W-1:0]    scale;
    logic signed [2*MID_W-1:0] prod;
    logic [SAMPLE_W-1:0]    rdata;
    logic signed [THR_W-1:0] lhs;
    logic [3:0]             cand;
    logic [FILL_W-1:0]      odd_pos;
    logic                   ram_we;

    nf4q_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_BLOCK)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_data.sample),
        .re    (cmd.rd_en),
        .raddr ({cmd.byte_idx, cmd.phase}),
        .rdata (rdata)
    );

    always_comb
    begin
        if (block_pairs_reg == '0)
        begin
            pairs_clamped = FILL_W'(1);
        end
        else if (FILL_W'(block_pairs_reg) > FILL_W'(MAX_PAIRS))
        begin
            pairs_clamped = FILL_W'(MAX_PAIRS);
        end
        else
        begin
            pairs_clamped = FILL_W'(block_pairs_reg);
        end
    end

    assign blk_len  = FILL_W'({pairs_clamped, 1'b0});
    assign fill_inc = (fill_reg < FILL_W'(MAX_BLOCK)) ? fill_reg + FILL_W'(1) : fill_reg;
    assign ram_we   = cmd.load && (fill_reg < FILL_W'(MAX_BLOCK));
    assign mag      = in_data.sample[SAMPLE_W-1] ? (~in_data.sample + SAMPLE_W'(1))
                                                 : in_data.sample;
    assign scale    = (absmax_reg == '0) ? SAMPLE_W'(1) : absmax_reg;
    assign prod     = nf4_mid(cmd.thr_sel) * $signed({1'b0, scale});
    assign lhs      = $signed({rdata[SAMPLE_W-1], rdata, 16'h0000});
    assign cand     = idx_reg | (4'b1000 >> cmd.step);
    assign odd_pos  = FILL_W'({cmd.byte_idx, 1'b1});

    assign stat.close_blk = in_data.last_in_tensor || (fill_inc >= blk_len);
    assign stat.lo_absent = odd_pos >= fill_reg;
    assign stat.last_byte = (odd_pos + FILL_W'(1)) >= fill_reg;

    always_comb
    begin
        fill_next   = fill_reg;
        absmax_next = absmax_reg;
        if (cmd.load)
        begin
            fill_next = fill_inc;
            if (mag > absmax_reg)
            begin
                absmax_next = mag;
            end
        end
        if (cmd.clear)
        begin
            fill_next   = '0;
            absmax_next = '0;
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        byte_next = byte_reg;
        if (cmd.rd_en)
        begin
            idx_next = '0;
        end
        else if (cmd.srch_en)
        begin
            if (lhs > thr_reg[4'(cand - 4'd1)])
            begin
                idx_next = cand;
            end
            if (cmd.step == STEP_W'(3))
            begin
                if (cmd.phase)
                begin
                    byte_next = {byte_reg[7:4], idx_next};
                end
                else
                begin
                    byte_next = {idx_next, 4'h0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_pairs_reg <= PAIRS_RESET;
            fill_reg        <= '0;
            absmax_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_pairs_reg <= cfg_wdata;
            end
            fill_reg   <= fill_next;
            absmax_reg <= absmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        if (cmd.load)
        begin
            tlast_reg <= in_data.last_in_tensor;
        end
        if (cmd.thr_en)
        begin
            thr_reg[cmd.thr_sel] <= prod[THR_W-1:0];
        end
    end

    assign out_data.packed_byte    = byte_reg;
    assign out_data.block_scale    = scale;
    assign out_data.last_of_block  = stat.last_byte;
    assign out_data.last_of_tensor = stat.last_byte && tlast_reg;

endmodule

`default_nettype wire

// File: src/nf4q_ctrl.sv
// ----------------------------------------------------------------------------
// nf4q_ctrl
// Sequencer for loading a block, building thresholds and emitting bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module nf4q_ctrl
    import nf4q_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_THR,
        S_RD,
        S_SRCH,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic              in_ready_reg;
    logic              out_valid_reg;
    logic [3:0]        thr_cnt_reg;
    logic [BYTE_W-1:0] byte_idx_reg;
    logic              phase_reg;
    logic [STEP_W-1:0] step_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = in_valid && in_ready_reg;
    assign out_acc = out_valid_reg && out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_acc;
        cmd.thr_en   = (state_reg == S_THR);
        cmd.thr_sel  = thr_cnt_reg;
        cmd.rd_en    = (state_reg == S_RD);
        cmd.srch_en  = (state_reg == S_SRCH);
        cmd.step     = step_reg;
        cmd.byte_idx = byte_idx_reg;
        cmd.phase    = phase_reg;
        cmd.clear    = out_acc && stat.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            thr_cnt_reg   <= '0;
            byte_idx_reg  <= '0;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (in_acc && stat.close_blk)
                    begin
                        state_reg    <= S_THR;
                        in_ready_reg <= 1'b0;
                        thr_cnt_reg  <= '0;
                    end
                end
                S_THR:
                begin
                    if (thr_cnt_reg == 4'(NUM_MIDS - 1))
                    begin
                        state_reg    <= S_RD;
                        byte_idx_reg <= '0;
                        phase_reg    <= 1'b0;
                    end
                    else
                    begin
                        thr_cnt_reg <= thr_cnt_reg + 4'd1;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_SRCH;
                    step_reg  <= '0;
                end
                S_SRCH:
                begin
                    if (step_reg == STEP_W'(3))
                    begin
                        if (!phase_reg && !stat.lo_absent)
                        begin
                            phase_reg <= 1'b1;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (stat.last_byte)
                        begin
                            state_reg    <= S_LOAD;
                            in_ready_reg <= 1'b1;
                        end
                        else
                        begin
                            byte_idx_reg <= byte_idx_reg + BYTE_W'(1);
                            phase_reg    <= 1'b0;
                            state_reg    <= S_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg     <= S_LOAD;
                    in_ready_reg  <= 1'b1;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/nf4_block_quantizer_unit.sv
// ----------------------------------------------------------------------------
// nf4_block_quantizer_unit
// NF4 block quantizer: buffers a block of signed samples and emits packed
// 4-bit indices, two per byte, each byte tagged with the block scale.
// ----------------------------------------------------------------------------
// Usage: samples enter on in_valid/in_ready, one item per cycle while a
// block is being loaded. A block closes when it holds twice block_pairs
// samples (block_pairs read as 1 when zero and capped at 32) or on an
// item marked last_in_tensor. The unit then stops taking items,
// multiplies the block scale by each NF4 midpoint (one shared
// multiplier), and then emits one byte item per sample pair on
// out_valid/out_ready. Each sample costs one block-store read plus a
// four-step binary search over the thresholds; a padded final byte holds
// a single sample in its high nibble. in_ready returns the cycle after
// the last byte is taken. When the receiver stalls, the byte item holds
// on out_data and the unit waits. Reset clears the fill count and
// maximum, sets block_pairs to 32 and leaves the unit ready for input.
// cfg_we writes block_pairs directly.
// ----------------------------------------------------------------------------
`default_nettype none

module nf4_block_quantizer_unit
    import nf4q_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [PAIRS_W-1:0] cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data
);

    cmd_t  cmd;
    stat_t stat;

    nf4q_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nf4q_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: src/nf4q_checker.sv
// ----------------------------------------------------------------------------
// nf4q_checker
// Port-level checks for the NF4 block quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nf4q_checker
    import nf4q_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // A stalled byte item holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // The unit never loads while a byte item is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output valid");

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.block_scale != '0)
        else $error("block scale is zero");

    a_tensor_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_of_tensor |-> out_data.last_of_block)
        else $error("tensor end without block end");

    // After the final byte of a block the unit returns to loading.
    a_block_end_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_of_block |=> in_ready && !out_valid)
        else $error("not ready after block end");

endmodule

bind nf4_block_quantizer_unit nf4q_checker u_nf4q_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
